// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertions on clk, off in reset except PSW_ASSERT_NEXT_ANY
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define PSW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define PSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication, also checked across reset
`define PSW_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// File: hdl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// widths, register indexes and the microcode program of the swap scrambler
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int WORD_W     = 32;
  localparam int SLOT_W     = 9;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 7;
  localparam int SWAP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // remainder unit retires two dividend bits per step
  localparam int DIV_STEPS = WORD_W / 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MOD_ITER,
    ST_MOD_STORE,
    ST_RUN_INIT,
    ST_SWAP_CHECK,
    ST_PT_RD_A,
    ST_PT_RD_B,
    ST_TB_RD_A,
    ST_TB_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_EMIT_INIT,
    ST_EMIT_RD,
    ST_EMIT,
    ST_OVER
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_DIV_STEP,
    OP_PT_WRITE,
    OP_RUN_INIT,
    OP_PT_RD_A,
    OP_PT_RD_B,
    OP_TB_RD_A,
    OP_TB_RD_B,
    OP_WR_A,
    OP_WR_B,
    OP_EMIT_INIT,
    OP_TB_RD_IDX,
    OP_EMIT,
    OP_EMIT_EMPTY
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_GO,
    C_LOAD_MODE,
    C_DIV_LAST,
    C_OVER,
    C_SWAPS_DONE,
    C_N_ZERO,
    C_EMIT_LAST
  } cond_t;

  typedef struct packed {
    logic  ready;
    logic  wait_out;
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctl_word_t;

  // control store: one word per step, jump to tgt_t when cond holds, else tgt_f
  function automatic ctl_word_t ucode(input step_t pc);
    ctl_word_t w;
    case (pc)
      ST_IDLE:       w = '{1'b1, 1'b0, OP_TAKE,       C_GO,         ST_DISPATCH,   ST_IDLE};
      ST_DISPATCH:   w = '{1'b0, 1'b0, OP_NOP,        C_LOAD_MODE,  ST_MOD_ITER,   ST_RUN_INIT};
      ST_MOD_ITER:   w = '{1'b0, 1'b0, OP_DIV_STEP,   C_DIV_LAST,   ST_MOD_STORE,  ST_MOD_ITER};
      ST_MOD_STORE:  w = '{1'b0, 1'b0, OP_PT_WRITE,   C_ALWAYS,     ST_IDLE,       ST_IDLE};
      ST_RUN_INIT:   w = '{1'b0, 1'b0, OP_RUN_INIT,   C_OVER,       ST_OVER,       ST_SWAP_CHECK};
      ST_SWAP_CHECK: w = '{1'b0, 1'b0, OP_NOP,        C_SWAPS_DONE, ST_EMIT_INIT,  ST_PT_RD_A};
      ST_PT_RD_A:    w = '{1'b0, 1'b0, OP_PT_RD_A,    C_ALWAYS,     ST_PT_RD_B,    ST_PT_RD_B};
      ST_PT_RD_B:    w = '{1'b0, 1'b0, OP_PT_RD_B,    C_ALWAYS,     ST_TB_RD_A,    ST_TB_RD_A};
      ST_TB_RD_A:    w = '{1'b0, 1'b0, OP_TB_RD_A,    C_ALWAYS,     ST_TB_RD_B,    ST_TB_RD_B};
      ST_TB_RD_B:    w = '{1'b0, 1'b0, OP_TB_RD_B,    C_ALWAYS,     ST_WR_A,       ST_WR_A};
      ST_WR_A:       w = '{1'b0, 1'b0, OP_WR_A,       C_ALWAYS,     ST_WR_B,       ST_WR_B};
      ST_WR_B:       w = '{1'b0, 1'b0, OP_WR_B,       C_ALWAYS,     ST_SWAP_CHECK, ST_SWAP_CHECK};
      ST_EMIT_INIT:  w = '{1'b0, 1'b0, OP_EMIT_INIT,  C_N_ZERO,     ST_IDLE,       ST_EMIT_RD};
      ST_EMIT_RD:    w = '{1'b0, 1'b0, OP_TB_RD_IDX,  C_ALWAYS,     ST_EMIT,       ST_EMIT};
      ST_EMIT:       w = '{1'b0, 1'b1, OP_EMIT,       C_EMIT_LAST,  ST_IDLE,       ST_EMIT_RD};
      ST_OVER:       w = '{1'b0, 1'b1, OP_EMIT_EMPTY, C_ALWAYS,     ST_IDLE,       ST_IDLE};
      default:       w = '{1'b1, 1'b0, OP_TAKE,       C_GO,         ST_DISPATCH,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/psw_if.sv
// ----------------------------------------------------------------------------
// psw_if
// request and result channels of the swap scrambler, valid/ready handshake
// ----------------------------------------------------------------------------
interface psw_in_if;
  import psw_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [WORD_W-1:0] random_word;
  logic [SLOT_W-1:0] pair_slot;
  logic [CHAR_W-1:0] text_char;
  logic              last_char;

  modport source (
    output valid, mode, random_word, pair_slot, text_char, last_char,
    input  ready
  );
  modport sink (
    input  valid, mode, random_word, pair_slot, text_char, last_char,
    output ready
  );
endinterface

interface psw_out_if;
  import psw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  modport source (
    output valid, out_char, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_char, out_last,
    output ready
  );
endinterface

// File: hdl/pairwise_swap_scrambler_unit.sv
// ----------------------------------------------------------------------------
// pairwise_swap_scrambler_unit
// swap-table loader and pairwise byte scrambler run by a microcoded sequencer
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    mode, random_word, pair_slot, text_char,
//                                 last_char
//   out_chan  out  valid/ready    out_char, out_last
//   cfg_*     in   cfg_we only    cfg_index, cfg_wdata
//
// a text byte that is not last is stored without leaving idle; a table load
// runs the remainder unit at two dividend bits per cycle, then writes the
// pair table; a run reads each swap's pair slots and text bytes in turn (pair
// table and text buffer each have one read port), writes both back and emits;
// a full output register holds the emit steps. no clearing pass after reset
// ----------------------------------------------------------------------------
module pairwise_swap_scrambler_unit #(
  parameter int MAX_DEPTH = 256,
  parameter int MAX_TEXT  = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  psw_in_if.sink                             in_chan,
  psw_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [psw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import psw_pkg::*;

  localparam int SLOTS     = 2 * MAX_DEPTH;
  localparam int SAW       = $clog2(SLOTS);
  localparam int PW        = $clog2(MAX_TEXT);
  localparam int CNTW      = $clog2(MAX_TEXT + 1);
  localparam int DEPTH_CAP = (MAX_DEPTH > 256) ? 256 : MAX_DEPTH;
  localparam logic [SWAP_W:0]  DEPTH_LIM = (SWAP_W + 1)'(DEPTH_CAP);
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_TEXT);
  localparam logic [CNTW-1:0]  TEXT_CAP  = CNTW'(MAX_TEXT);

  // sequencer
  step_t      pc_r, pc_nxt;
  ctl_word_t  ctl;
  op_t        op;
  logic       advance;
  logic       cond_ok;

  // configuration
  logic [LEN_W-1:0]  tlen_r;
  logic [SWAP_W-1:0] swaps_r;
  logic              dir_r;

  // datapath
  logic              mode_r;
  logic [SLOT_W-1:0] slot_r;
  logic [WORD_W-1:0] dq_r;
  logic [LEN_W-1:0]  rem_r;
  logic [LEN_W-1:0]  len_r;
  logic [CNTW-1:0]   count_r;
  logic [CNTW-1:0]   n_r;
  logic [SWAP_W-1:0] cnt_r;
  logic [SWAP_W-1:0] pidx_r;
  logic [PW-1:0]     pa_r, pb_r;
  logic [CHAR_W-1:0] da_r;
  logic [MAX_TEXT-1:0] tflag_r;
  logic [MAX_TEXT-1:0] run_mask;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic              accept;
  logic              out_free;
  logic              over_lim;
  logic              room;
  logic [SWAP_W-1:0] emit_nxt_idx;
  logic              emit_last;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W:0]    r1, r2;
  logic [LEN_W-1:0]  q1, q2;

  // memories
  logic              pt_we;
  logic [SAW-1:0]    pt_waddr, pt_raddr;
  logic [PW-1:0]     pt_rdata;
  logic              tb_we;
  logic [PW-1:0]     tb_waddr, tb_raddr;
  logic [CHAR_W-1:0] tb_wdata, tb_rdata;
  logic [CHAR_W-1:0] emit_char;

  assign ctl      = ucode(pc_r);
  assign out_free = !out_valid_r || out_chan.ready;
  assign advance  = !(ctl.wait_out && !out_free);
  assign accept   = in_chan.valid && in_chan.ready;
  assign over_lim = {1'b0, swaps_r} >= DEPTH_LIM;
  assign room     = count_r < TEXT_CAP;

  assign emit_nxt_idx = cnt_r + SWAP_W'(1);
  assign emit_last    = emit_nxt_idx == SWAP_W'(n_r);
  assign emit_char    = tflag_r[PW'(cnt_r)] ? tb_rdata : '0;

  always_comb begin
    if (tlen_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (tlen_r > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = tlen_r;
    end
  end

  // two restoring remainder steps per cycle
  always_comb begin
    r1 = {rem_r, dq_r[WORD_W-1]};
    q1 = (r1 >= {1'b0, len_r}) ? LEN_W'(r1 - {1'b0, len_r}) : LEN_W'(r1);
    r2 = {q1, dq_r[WORD_W-2]};
    q2 = (r2 >= {1'b0, len_r}) ? LEN_W'(r2 - {1'b0, len_r}) : LEN_W'(r2);
  end

  always_comb begin
    for (int i = 0; i < MAX_TEXT; i++) begin
      run_mask[i] = CNTW'(i) < count_r;
    end
  end

  // next step
  always_comb begin
    case (ctl.cond)
      C_ALWAYS:     cond_ok = 1'b1;
      C_GO:         cond_ok = accept && (!in_chan.mode || in_chan.last_char);
      C_LOAD_MODE:  cond_ok = !mode_r;
      C_DIV_LAST:   cond_ok = cnt_r == SWAP_W'(DIV_STEPS - 1);
      C_OVER:       cond_ok = over_lim;
      C_SWAPS_DONE: cond_ok = cnt_r == '0;
      C_N_ZERO:     cond_ok = n_r == '0;
      C_EMIT_LAST:  cond_ok = emit_last;
      default:      cond_ok = 1'b1;
    endcase
    if (!advance) begin
      pc_nxt = pc_r;
    end else if (cond_ok) begin
      pc_nxt = ctl.tgt_t;
    end else begin
      pc_nxt = ctl.tgt_f;
    end
  end

  // control word decode
  always_comb begin
    op            = advance ? ctl.op : OP_NOP;
    in_chan.ready = ctl.ready;

    pt_we    = (op == OP_PT_WRITE) && (32'(slot_r) < 32'(SLOTS));
    pt_waddr = SAW'(slot_r);
    pt_raddr = SAW'({pidx_r, op == OP_PT_RD_B});

    tb_we    = 1'b0;
    tb_waddr = PW'(count_r);
    tb_wdata = in_chan.text_char;
    case (op)
      OP_TAKE: begin
        tb_we = accept && in_chan.mode && room;
      end
      OP_WR_A: begin
        tb_we    = 1'b1;
        tb_waddr = pa_r;
        tb_wdata = tflag_r[pb_r] ? tb_rdata : '0;
      end
      OP_WR_B: begin
        tb_we    = 1'b1;
        tb_waddr = pb_r;
        tb_wdata = da_r;
      end
      default: ;
    endcase

    case (op)
      OP_TB_RD_A: tb_raddr = pa_r;
      OP_TB_RD_B: tb_raddr = pb_r;
      default:    tb_raddr = PW'(cnt_r);
    endcase

    out_valid_nxt = out_valid_r;
    if (op == OP_EMIT || op == OP_EMIT_EMPTY) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      tlen_r      <= LEN_W'(1);
      swaps_r     <= '0;
      dir_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_LENGTH: tlen_r  <= cfg_wdata[LEN_W-1:0];
          CFG_SWAP_COUNT:  swaps_r <= cfg_wdata[SWAP_W-1:0];
          CFG_DIRECTION:   dir_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (op == OP_TAKE && accept && in_chan.mode && room) begin
        count_r <= count_r + CNTW'(1);
      end else if (op == OP_RUN_INIT) begin
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_TAKE: begin
        if (accept) begin
          mode_r <= in_chan.mode;
          slot_r <= in_chan.pair_slot;
          dq_r   <= in_chan.random_word;
          rem_r  <= '0;
          len_r  <= eff_len;
          cnt_r  <= '0;
        end
      end
      OP_DIV_STEP: begin
        rem_r <= q2;
        dq_r  <= dq_r << 2;
        cnt_r <= cnt_r + SWAP_W'(1);
      end
      OP_RUN_INIT: begin
        n_r     <= count_r;
        cnt_r   <= swaps_r;
        pidx_r  <= dir_r ? swaps_r - SWAP_W'(1) : '0;
        tflag_r <= run_mask;
      end
      OP_PT_RD_B: pa_r <= pt_rdata;
      OP_TB_RD_A: pb_r <= pt_rdata;
      OP_TB_RD_B: da_r <= tflag_r[pa_r] ? tb_rdata : '0;
      OP_WR_A:    tflag_r[pa_r] <= 1'b1;
      OP_WR_B: begin
        tflag_r[pb_r] <= 1'b1;
        cnt_r         <= cnt_r - SWAP_W'(1);
        pidx_r        <= dir_r ? pidx_r - SWAP_W'(1) : pidx_r + SWAP_W'(1);
      end
      OP_EMIT_INIT: cnt_r <= '0;
      OP_EMIT: begin
        out_char_r <= emit_char;
        out_last_r <= emit_last;
        cnt_r      <= emit_nxt_idx;
      end
      OP_EMIT_EMPTY: begin
        out_char_r <= '0;
        out_last_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.out_last = out_last_r;

  psw_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (PW'(rem_r)),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  psw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

endmodule

// File: hdl/psw_ram.sv
// ----------------------------------------------------------------------------
// psw_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module psw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/psw_chk.sv
// ----------------------------------------------------------------------------
// psw_chk
// port-level checks on the swap scrambler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psw_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_mode,
  input logic                      in_last_char,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [psw_pkg::CHAR_W-1:0] out_char,
  input logic                      out_last
);
  import psw_pkg::*;

  // reset empties the output register
  `PSW_ASSERT_NEXT_ANY(a_reset_empty, !rst_n, !out_valid)

  // a stalled result stays put
  `PSW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last))

  // no new request while a run still has bytes to send
  `PSW_ASSERT_SAME(a_run_busy, out_valid && !out_last, !in_ready)

  // table loads and run starts keep the sequencer busy next cycle
  `PSW_ASSERT_NEXT(a_busy_after, in_valid && in_ready && (!in_mode || in_last_char), !in_ready)

endmodule

bind pairwise_swap_scrambler_unit psw_chk u_psw_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_mode      (in_chan.mode),
  .in_last_char (in_chan.last_char),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_char     (out_chan.out_char),
  .out_last     (out_chan.out_last)
);
